// ===== sv/tsabc_pkg.sv =====
// Shared types and constants of the temperature band classifier.
package tsabc_pkg;

	localparam int AVG_CODE_W = 10;
	localparam int DEG_W      = 9;
	localparam int REG_IDX_W  = 2;

	localparam logic [REG_IDX_W-1:0] REG_GREEN_LOW   = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_GREEN_HIGH  = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_YELLOW_HIGH = 2'd2;

	localparam logic signed [DEG_W-1:0] GREEN_LOW_RST   = 9'sd19;
	localparam logic signed [DEG_W-1:0] GREEN_HIGH_RST  = 9'sd22;
	localparam logic signed [DEG_W-1:0] YELLOW_HIGH_RST = 9'sd25;

	typedef enum logic [1:0] {
		BAND_COLD   = 2'd0,
		BAND_GREEN  = 2'd1,
		BAND_YELLOW = 2'd2,
		BAND_RED    = 2'd3
	} band_t;

	typedef struct packed {
		logic signed [DEG_W-1:0] green_low;
		logic signed [DEG_W-1:0] green_high;
		logic signed [DEG_W-1:0] yellow_high;
	} limits_t;

	typedef struct packed {
		logic [AVG_CODE_W-1:0]   average_code;
		logic signed [DEG_W-1:0] degrees;
		band_t                   band;
	} result_t;

endpackage

// ===== sv/tsabc_fifo.sv =====
// Small register queue used between the accumulator, the scaling pipeline and the output.
module tsabc_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue count beyond depth");

	a_push_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full && !pop) |=> !empty)
		else $error("queue empty after a request was pushed");
`endif

endmodule

// ===== sv/tsabc_front.sv =====
// Front end: accumulates samples and hands each completed block sum on.
module tsabc_front #(
	parameter int BLOCK_SAMPLES = 8,
	parameter int SAMPLE_BITS   = 10,
	parameter int SUM_W         = 13
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  logic [SAMPLE_BITS-1:0] sample,
	output logic                   full,
	input  logic                   sum_full,
	output logic                   sum_push,
	output logic [SUM_W-1:0]       sum_data
);

	localparam int CNT_W = $clog2(BLOCK_SAMPLES);

	logic [CNT_W-1:0] count_q;
	logic [SUM_W-1:0] sum_q;
	logic             last;
	logic             accept;

	assign last     = (count_q == CNT_W'(BLOCK_SAMPLES - 1));
	// stall only the sample that closes a block while the handoff queue is full
	assign full     = last && sum_full;
	assign accept   = push && !full;
	assign sum_data = sum_q + SUM_W'(sample);
	assign sum_push = accept && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_q   <= '0;
		end else if (accept) begin
			if (last) begin
				count_q <= '0;
				sum_q   <= '0;
			end else begin
				count_q <= count_q + 1'b1;
				sum_q   <= sum_data;
			end
		end
	end

`ifndef SYNTH
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(BLOCK_SAMPLES - 1))
		else $error("sample count beyond block size");

	a_block_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && last) |=> (count_q == '0 && sum_q == '0))
		else $error("accumulator not cleared after block");
`endif

endmodule

// ===== sv/tsabc_back.sv =====
// Back end: scales each block sum into average, degrees and band over four stages.
module tsabc_back #(
	parameter int BLOCK_SAMPLES = 8,
	parameter int SAMPLE_BITS   = 10,
	parameter int SUM_W         = 13
) (
	input  logic               clk,
	input  logic               arst_n,
	input  tsabc_pkg::limits_t limits,
	input  logic               sum_empty,
	input  logic [SUM_W-1:0]   sum_data,
	output logic               sum_pop,
	input  logic               res_full,
	output logic               res_push,
	output tsabc_pkg::result_t res_data
);

	localparam int AVG_W  = SAMPLE_BITS;
	// exact floor division by the block size through a reciprocal
	localparam int S_AVG  = SUM_W + $clog2(BLOCK_SAMPLES);
	localparam int M_AVG_W = SUM_W + 1;
	localparam logic [M_AVG_W-1:0] M_AVG =
		M_AVG_W'((2 ** S_AVG + BLOCK_SAMPLES - 1) / BLOCK_SAMPLES);
	localparam int HALF   = BLOCK_SAMPLES / 2;
	localparam int MAG_W  = AVG_W + 2;
	localparam int T_W    = AVG_W + 3;
	// exact floor division by ten through a reciprocal
	localparam int S10    = MAG_W + 4;
	localparam int M10_W  = MAG_W + 1;
	localparam logic [M10_W-1:0] M10 = M10_W'((2 ** S10 + 9) / 10);
	localparam int Q_W    = MAG_W - 3;
	localparam int D_W    = (MAG_W - 2 > 10) ? MAG_W - 2 : 10;
	localparam int DW     = tsabc_pkg::DEG_W;

	logic                       en;
	logic                       v_s1, v_s2, v_s3, v_s4;
	logic [SUM_W-1:0]           x_s1;
	logic [SUM_W+M_AVG_W-1:0]   p_s2;
	logic [AVG_W-1:0]           avg_s3, avg_s4;
	logic [MAG_W-1:0]           mag_s3;
	logic                       neg_s3, neg_s4;
	logic [MAG_W+M10_W-1:0]     p_s4;

	logic [AVG_W-1:0]           avg_c;
	logic [T_W-1:0]             avg5_c;
	logic signed [T_W-1:0]      t_c;
	logic [Q_W-1:0]             q_c;
	logic signed [D_W-1:0]      d_c;
	logic signed [DW-1:0]       deg_c;
	tsabc_pkg::band_t           band_c;

	// hold the whole pipeline while its last stage cannot drain
	assign en      = !(v_s4 && res_full);
	assign sum_pop = en && !sum_empty;

	assign avg_c  = p_s2[S_AVG +: AVG_W];
	assign avg5_c = {avg_c, 2'b00} + T_W'(avg_c);
	assign t_c    = $signed(T_W'(avg5_c >> 1)) - T_W'(500);

	assign q_c = p_s4[S10 +: Q_W];
	assign d_c = neg_s4 ? -$signed(D_W'(q_c)) : $signed(D_W'(q_c));

	always_comb begin
		priority if (d_c < -D_W'(256)) begin
			deg_c = -DW'(256);
		end else if (d_c > D_W'(255)) begin
			deg_c = DW'(255);
		end else begin
			deg_c = DW'(d_c);
		end
	end

	always_comb begin
		priority if (deg_c >= limits.green_low && deg_c <= limits.green_high) begin
			band_c = tsabc_pkg::BAND_GREEN;
		end else if (deg_c < limits.green_low) begin
			band_c = tsabc_pkg::BAND_COLD;
		end else if (deg_c <= limits.yellow_high) begin
			band_c = tsabc_pkg::BAND_YELLOW;
		end else begin
			band_c = tsabc_pkg::BAND_RED;
		end
	end

	assign res_push              = v_s4 && en;
	assign res_data.average_code = tsabc_pkg::AVG_CODE_W'(avg_s4);
	assign res_data.degrees      = deg_c;
	assign res_data.band         = band_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= !sum_empty;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1   <= sum_data + SUM_W'(HALF);
			p_s2   <= (SUM_W+M_AVG_W)'(x_s1) * (SUM_W+M_AVG_W)'(M_AVG);
			avg_s3 <= avg_c;
			neg_s3 <= t_c[T_W-1];
			mag_s3 <= t_c[T_W-1] ? MAG_W'(-t_c) : MAG_W'(t_c);
			avg_s4 <= avg_s3;
			neg_s4 <= neg_s3;
			p_s4   <= (MAG_W+M10_W)'(mag_s3) * (MAG_W+M10_W)'(M10);
		end
	end

`ifndef SYNTH
	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("result pushed into a full queue");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> v_s4)
		else $error("stalled result lost from last stage");
`endif

endmodule

// ===== sv/temp_sensor_average_band_classifier.sv =====
// Top level of the block-average temperature band classifier.
// Takes one sample per clock; every BLOCK_SAMPLES accepted samples yield one result
// (rounded average, whole degrees, band code). The accumulator front end hands each
// block sum through a two-entry queue to a four-stage scaling pipeline (two
// reciprocal multiplies, each followed by a register), whose results wait in a
// two-entry output queue. Each block sum passes through the handoff queue and pipeline
// stages to the output queue. The front stalls only when the closing sample finds
// the handoff queue full; the pipeline stalls only when the output queue is full.
// Limit registers: index 0 green low, 1 green high, 2 yellow high; others ignored.
module temp_sensor_average_band_classifier #(
	parameter int BLOCK_SAMPLES = 8,
	parameter int SAMPLE_BITS   = 10
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   push,
	output logic                                   full,
	input  logic [SAMPLE_BITS-1:0]                 sample,
	output logic                                   empty,
	input  logic                                   pop,
	output logic [tsabc_pkg::AVG_CODE_W-1:0]       average_code,
	output logic signed [tsabc_pkg::DEG_W-1:0]     degrees,
	output logic [1:0]                             band,
	input  logic                                   wr_en,
	input  logic [tsabc_pkg::REG_IDX_W-1:0]        wr_index,
	input  logic [tsabc_pkg::DEG_W-1:0]            wr_data
);

	localparam int SUM_W = SAMPLE_BITS + $clog2(BLOCK_SAMPLES);
	localparam int RES_W = $bits(tsabc_pkg::result_t);

	tsabc_pkg::limits_t limits_q;
	logic               sum_push, sum_pop, sum_full, sum_empty;
	logic [SUM_W-1:0]   sum_in, sum_out;
	logic               res_push, res_full;
	tsabc_pkg::result_t res_in, res_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limits_q.green_low   <= tsabc_pkg::GREEN_LOW_RST;
			limits_q.green_high  <= tsabc_pkg::GREEN_HIGH_RST;
			limits_q.yellow_high <= tsabc_pkg::YELLOW_HIGH_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				tsabc_pkg::REG_GREEN_LOW:   limits_q.green_low   <= $signed(wr_data);
				tsabc_pkg::REG_GREEN_HIGH:  limits_q.green_high  <= $signed(wr_data);
				tsabc_pkg::REG_YELLOW_HIGH: limits_q.yellow_high <= $signed(wr_data);
				default: ;
			endcase
		end
	end

	tsabc_front #(
		.BLOCK_SAMPLES(BLOCK_SAMPLES),
		.SAMPLE_BITS  (SAMPLE_BITS),
		.SUM_W        (SUM_W)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.sample  (sample),
		.full    (full),
		.sum_full(sum_full),
		.sum_push(sum_push),
		.sum_data(sum_in)
	);

	tsabc_fifo #(
		.WIDTH(SUM_W),
		.DEPTH(2)
	) u_sum_q (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (sum_push),
		.push_data(sum_in),
		.full     (sum_full),
		.pop      (sum_pop),
		.pop_data (sum_out),
		.empty    (sum_empty)
	);

	tsabc_back #(
		.BLOCK_SAMPLES(BLOCK_SAMPLES),
		.SAMPLE_BITS  (SAMPLE_BITS),
		.SUM_W        (SUM_W)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.limits   (limits_q),
		.sum_empty(sum_empty),
		.sum_data (sum_out),
		.sum_pop  (sum_pop),
		.res_full (res_full),
		.res_push (res_push),
		.res_data (res_in)
	);

	tsabc_fifo #(
		.WIDTH(RES_W),
		.DEPTH(2)
	) u_res_q (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (res_push),
		.push_data(res_in),
		.full     (res_full),
		.pop      (pop),
		.pop_data (res_out),
		.empty    (empty)
	);

	assign average_code = res_out.average_code;
	assign degrees      = res_out.degrees;
	assign band         = res_out.band;

`ifndef SYNTH
	a_limits_held: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(wr_en) |-> $stable(limits_q))
		else $error("limit registers changed without a write request");
`endif

endmodule
